// File: hw/rtl/best_fit_block_allocator_core_macros.svh
// Assertion macros for the best-fit allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bfa check failed");

// next-cycle implication
`define BFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bfa check failed");

`endif

// File: hw/rtl/bfa_pkg.sv
// Shared types and constants of the best-fit allocator.
// No dependencies; used by the interfaces and by every module.
package bfa_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int BIU_W          = 5;
	localparam int IDX_W          = 4;
	localparam int AMT_W          = 32;
	localparam int STATUS_W       = 2;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_LOADED  = 2'd0,
		STATUS_GRANTED = 2'd1,
		STATUS_REFUSED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0, // write a capacity
		CMD_SKIP   = 2'd1, // load outside the table, answer only
		CMD_ALLOC  = 2'd2, // run a search
		CMD_REFUSE = 2'd3  // allocate with nothing to search
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [IDX_W-1:0]       index;
		logic [AMT_W-1:0]       amount;
		logic                   last;
		logic [BIU_W-1:0]       limit;
	} cmd_t;

endpackage

// File: hw/rtl/bfa_item_if.sv
// Input channel of the best-fit allocator: valid/ready plus one request.
// Depends on bfa_pkg for field widths.
interface bfa_item_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [bfa_pkg::IDX_W-1:0]   load_index;
	logic [bfa_pkg::AMT_W-1:0]   amount;
	logic                        last_request;

	modport source(output valid, output operation, output load_index, output amount,
		output last_request, input ready);
	modport sink(input valid, input operation, input load_index, input amount,
		input last_request, output ready);
endinterface

// File: hw/rtl/bfa_result_if.sv
// Result channel of the best-fit allocator: valid/ready plus one result.
// Depends on bfa_pkg for field widths.
interface bfa_result_if;
	logic                          valid;
	logic                          ready;
	logic [bfa_pkg::STATUS_W-1:0]  status;
	logic [bfa_pkg::IDX_W-1:0]     chosen_block;
	logic                          last_result;

	modport source(output valid, output status, output chosen_block, output last_result,
		input ready);
	modport sink(input valid, input status, input chosen_block, input last_result,
		output ready);
endinterface

// File: hw/rtl/best_fit_block_allocator_core.sv
// Best-fit block allocator: front end, command queue, back end with table.
// Depends on bfa_pkg, bfa_item_if, bfa_result_if, bfa_front, bfa_queue, bfa_back.
//
// Usage:
//   item   - request channel (valid/ready). operation 0 loads amount into
//            entry load_index; operation 1 asks for amount from the best fit.
//   result - one result per request, in order: status loaded / allocated /
//            not allocated, chosen_block, and last_result echoing last_request.
//   cfg_we/cfg_wdata - writes blocks_in_use (the search limit saturates at
//            MAX_BLOCKS, at most 31); only while no request is in flight.
// Timing:
//   A load is written when the back end pops it and its result is registered;
//   loads stream at one per cycle while idle and while result.ready is high.
//   An allocate runs in the back end as pop, one table read per entry up to
//   the search limit, compare drain and write-back, which waits for a free
//   result register. The single table read port makes the scan sequential.
// Reset: queue and result register empty, blocks_in_use back to 16; table
//   contents are undefined until loaded.
// Stalls: the result register holds while result.ready is low; the queue
//   keeps accepting up to its depth, then item.ready drops.
module best_fit_block_allocator_core #(
	parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bfa_item_if.sink                    item,
	bfa_result_if.source                result,
	input  logic                        cfg_we,
	input  logic [bfa_pkg::BIU_W-1:0]   cfg_wdata
);

	// search width register
	logic [bfa_pkg::BIU_W-1:0] blocks_in_use_q;

	logic          push;
	bfa_pkg::cmd_t push_cmd;
	logic          pop;
	logic          queue_full;
	logic          queue_nonempty;
	bfa_pkg::cmd_t head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= bfa_pkg::BIU_RESET;
		end else if (cfg_we) begin
			blocks_in_use_q <= cfg_wdata;
		end
	end

	// classify requests, saturate the search limit
	bfa_front #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_front (
		.item          (item),
		.blocks_in_use (blocks_in_use_q),
		.queue_full    (queue_full),
		.push          (push),
		.cmd           (push_cmd)
	);

	// decouples acceptance from the scan
	bfa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (queue_full),
		.nonempty (queue_nonempty),
		.head     (head_cmd)
	);

	// table, scan and result register
	bfa_back #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_nonempty),
		.cmd       (head_cmd),
		.pop       (pop),
		.result    (result)
	);

endmodule

// File: hw/rtl/bfa_front.sv
// Front end: accepts requests and turns them into queue commands.
// Depends on bfa_pkg and bfa_item_if.
module bfa_front #(
	parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
	bfa_item_if.sink                    item,
	input  logic [bfa_pkg::BIU_W-1:0]   blocks_in_use,
	input  logic                        queue_full,
	output logic                        push,
	output bfa_pkg::cmd_t               cmd
);

	localparam int SAT     = (MAX_BLOCKS < 31) ? MAX_BLOCKS : 31;
	localparam int IDX_LIM = (MAX_BLOCKS < 16) ? MAX_BLOCKS : 16;

	logic [bfa_pkg::BIU_W-1:0] limit;
	logic                      idx_ok;

	assign limit  = (blocks_in_use > bfa_pkg::BIU_W'(SAT)) ? bfa_pkg::BIU_W'(SAT)
		: blocks_in_use;
	assign idx_ok = ({1'b0, item.load_index} < (bfa_pkg::IDX_W + 1)'(IDX_LIM));

	assign item.ready = !queue_full;
	assign push       = item.valid && !queue_full;

	always_comb begin
		cmd.index  = item.load_index;
		cmd.amount = item.amount;
		cmd.last   = item.last_request;
		cmd.limit  = limit;
		if (!item.operation) begin
			cmd.kind = idx_ok ? bfa_pkg::CMD_LOAD : bfa_pkg::CMD_SKIP;
		end else begin
			cmd.kind = (limit == '0) ? bfa_pkg::CMD_REFUSE : bfa_pkg::CMD_ALLOC;
		end
	end

endmodule

// File: hw/rtl/bfa_queue.sv
// Small command FIFO between front and back end.
// Depends on bfa_pkg.
module bfa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bfa_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            nonempty,
	output bfa_pkg::cmd_t   head
);

	localparam int DEPTH = bfa_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bfa_pkg::cmd_t     slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/bfa_back.sv
// Back end: capacity table, sequential best-fit scan and result register.
// Depends on bfa_pkg, bfa_result_if and the assertion macro header.
`include "best_fit_block_allocator_core_macros.svh"

module bfa_back #(
	parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  bfa_pkg::cmd_t   cmd,
	output logic            pop,
	bfa_result_if.source    result
);

	localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW    = bfa_pkg::BIU_W;
	localparam int AMT_W = bfa_pkg::AMT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_WRITE} state_t;

	logic [AMT_W-1:0]   mem [MAX_BLOCKS];

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      limit_q;
	logic [AMT_W-1:0]   amt_q;
	logic               last_q;
	logic               found_q;
	logic [CW-1:0]      best_q;
	logic [AMT_W-1:0]   best_cap_q;
	logic               rd_vld_s1;
	logic [CW-1:0]      rd_idx_s1;
	logic [AMT_W-1:0]   rdata_s1;
	logic               res_valid_q;
	bfa_pkg::status_t   res_status_q;
	logic [bfa_pkg::IDX_W-1:0] res_block_q;
	logic               res_last_q;

	logic               res_free;
	logic               res_set;
	logic               alloc_pop;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [AMT_W-1:0]   mem_wd;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               better;

	logic [AW+bfa_pkg::IDX_W-1:0] ld_addr_ext;
	logic [AW+CW-1:0]             cnt_ext;
	logic [AW+CW-1:0]             best_ext;

	assign ld_addr_ext = (AW + bfa_pkg::IDX_W)'(cmd.index);
	assign cnt_ext     = (AW + CW)'(cnt_q);
	assign best_ext    = (AW + CW)'(best_q);
	assign rd_addr     = cnt_ext[AW-1:0];

	assign res_free  = !res_valid_q || result.ready;
	assign pop       = (state_q == ST_IDLE) && cmd_valid && res_free;
	assign alloc_pop = pop && (cmd.kind == bfa_pkg::CMD_ALLOC);
	// a new result is loaded when any non-allocate command is popped or by the end of a scan
	assign res_set   = (pop && !alloc_pop) || (state_q == ST_WRITE && res_free);
	assign rd_en     = (state_q == ST_SCAN);
	assign better    = rd_vld_s1 && (rdata_s1 >= amt_q) && (!found_q || rdata_s1 < best_cap_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ld_addr_ext[AW-1:0];
		mem_wd = cmd.amount;
		if (pop && cmd.kind == bfa_pkg::CMD_LOAD) begin
			mem_we = 1'b1;
		end else if (state_q == ST_WRITE && found_q && res_free) begin
			mem_we = 1'b1;
			mem_wa = best_ext[AW-1:0];
			mem_wd = best_cap_q - amt_q;
		end
	end

	// single-port table, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			rd_vld_s1 <= rd_en;
			rd_idx_s1 <= cnt_q;
			if (better) begin
				found_q    <= 1'b1;
				best_q     <= rd_idx_s1;
				best_cap_q <= rdata_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (cmd.kind)
							bfa_pkg::CMD_ALLOC: begin
								state_q <= ST_SCAN;
								cnt_q   <= '0;
								limit_q <= cmd.limit;
								amt_q   <= cmd.amount;
								last_q  <= cmd.last;
								found_q <= 1'b0;
							end
							bfa_pkg::CMD_REFUSE: begin
								res_status_q <= bfa_pkg::STATUS_REFUSED;
								res_block_q  <= '0;
								res_last_q   <= cmd.last;
							end
							default: begin
								res_status_q <= bfa_pkg::STATUS_LOADED;
								res_block_q  <= '0;
								res_last_q   <= cmd.last;
							end
						endcase
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == limit_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (res_free) begin
						res_status_q <= found_q ? bfa_pkg::STATUS_GRANTED
							: bfa_pkg::STATUS_REFUSED;
						res_block_q  <= found_q ? best_q[bfa_pkg::IDX_W-1:0] : '0;
						res_last_q   <= last_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = res_valid_q;
	assign result.status       = res_status_q;
	assign result.chosen_block = res_block_q;
	assign result.last_result  = res_last_q;

	`BFA_ASSERT_IMP(a_no_rw_clash, clk, arst_n, mem_we, !rd_en)
	`BFA_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == ST_SCAN, cnt_q < limit_q)
	`BFA_ASSERT_IMP(a_grant_fits, clk, arst_n, state_q == ST_WRITE && found_q, best_cap_q >= amt_q)
	`BFA_ASSERT_NXT(a_alloc_start, clk, arst_n, alloc_pop, state_q == ST_SCAN && cnt_q == '0)

endmodule
